>>> rtl/core/double_ended_priority_queue_assert.svh
// Assertion macros for the priority queue RTL.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dpq_pkg.sv
// Types, codes and constants of the double-ended priority queue.
`default_nettype none
package dpq_pkg;

  localparam int VALUE_W      = 32;
  localparam int FILL_W       = 7;
  localparam int REQ_W        = 2;
  localparam int ERR_W        = 2;
  localparam int CAPACITY_DEF = 64;
  localparam int GROUP_SIZE   = 8;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP_MIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_MAX = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_MIN,
    OP_POP_MAX
  } cell_op_t;

  typedef struct packed {
    logic                      vld;
    logic                      keep;
    logic signed [VALUE_W-1:0] val;
  } cell_link_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic [FILL_W-1:0]         fill_level;
    logic                      is_empty;
    logic                      is_full;
    logic [ERR_W-1:0]          error_code;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/double_ended_priority_queue.sv
// Top level of the double-ended priority queue: a sorted chain of cells.
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at the
//   rising edge where start is high and busy is low. req_type picks insert,
//   remove minimum or remove maximum; value is used by inserts only.
//   Result channel: out_valid is high for exactly one cycle with out_item,
//   one result per item. The receiver cannot stall; the result is gone after
//   that cycle.
//   Pipeline: the cells update at the accepting edge, the maximum is then
//   found through a registered OR tree of groups, and the output register
//   loads after the group registers. busy stays high from accept until the
//   output register loads, so the block takes no new item before it is
//   through with the last; the two-level max tree over the cell chain is
//   what makes it wait.
//   Reset (rst_n low, synchronous): all cells go empty, the count clears
//   and no result is pending. Values in empty cells are never read.
//   Errors: a removal from an empty queue or an insert into a full queue
//   leaves the contents untouched and reports the error code.
`default_nettype none
module double_ended_priority_queue #(
  parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  dpq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output dpq_pkg::out_item_t  out_item
);

  `include "double_ended_priority_queue_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + dpq_pkg::GROUP_SIZE - 1) / dpq_pkg::GROUP_SIZE;

  logic                               accept;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic                               s1_r, s2_r, out_valid_r;
  logic [dpq_pkg::ERR_W-1:0]          err_nxt, err_r;
  logic signed [dpq_pkg::VALUE_W-1:0] removed_nxt, removed_r;
  dpq_pkg::cell_op_t                  op;
  dpq_pkg::out_item_t                 out_r;
  logic                               is_empty, is_full;

  dpq_pkg::cell_link_t                lnk   [CAPACITY+2];
  logic [dpq_pkg::VALUE_W-1:0]        lastv [CAPACITY];
  logic [dpq_pkg::VALUE_W-1:0]        grp_r [NGRP];
  logic [dpq_pkg::VALUE_W-1:0]        max_or;

  assign accept   = start && !busy;
  assign busy     = s1_r || s2_r;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(CAPACITY));

  // Decode the request: pick the chain operation, error and removed value
  always_comb begin
    op          = dpq_pkg::OP_HOLD;
    err_nxt     = dpq_pkg::ERR_NONE;
    removed_nxt = '0;
    count_nxt   = count_r;
    case (in_item.req_type)
      dpq_pkg::REQ_INSERT: begin
        if (is_full) begin
          err_nxt = dpq_pkg::ERR_FULL;
        end else begin
          op        = dpq_pkg::OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      dpq_pkg::REQ_POP_MIN: begin
        if (is_empty) begin
          err_nxt = dpq_pkg::ERR_EMPTY;
        end else begin
          op          = dpq_pkg::OP_POP_MIN;
          removed_nxt = lnk[1].val;
          count_nxt   = count_r - 1'b1;
        end
      end
      dpq_pkg::REQ_POP_MAX: begin
        if (is_empty) begin
          err_nxt = dpq_pkg::ERR_EMPTY;
        end else begin
          // the last reported maximum is still the current one while idle
          op          = dpq_pkg::OP_POP_MAX;
          removed_nxt = out_r.max_value;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      op = dpq_pkg::OP_HOLD;
    end
  end

  // Chain boundaries: the left end always keeps, the right end is empty
  assign lnk[0]          = '{vld: 1'b1, keep: 1'b1, val: '0};
  assign lnk[CAPACITY+1] = '{vld: 1'b0, keep: 1'b0, val: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .ins_val   (in_item.value),
      .lnk_left  (lnk[i]),
      .lnk_right (lnk[i+2]),
      .lnk       (lnk[i+1]),
      .last_val  (lastv[i])
    );
  end

  // First level of the max tree: only the last valid cell drives a value
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      logic [dpq_pkg::VALUE_W-1:0] acc;
      acc = '0;
      for (int j = 0; j < dpq_pkg::GROUP_SIZE; j++) begin
        if (g * dpq_pkg::GROUP_SIZE + j < CAPACITY) begin
          acc = acc | lastv[g * dpq_pkg::GROUP_SIZE + j];
        end
      end
      grp_r[g] <= acc;
    end
  end

  always_comb begin
    max_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      max_or = max_or | grp_r[g];
    end
  end

  // Control: advance the item through decode, tree and output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      s1_r        <= accept;
      s2_r        <= s1_r;
      out_valid_r <= s2_r;
    end
  end

  // Payload: hold the decode results and load the output item
  always_ff @(posedge clk) begin
    if (accept) begin
      err_r     <= err_nxt;
      removed_r <= removed_nxt;
    end
    if (s2_r) begin
      out_r.removed_value <= removed_r;
      out_r.min_value     <= lnk[1].vld ? lnk[1].val : '0;
      out_r.max_value     <= max_or;
      out_r.fill_level    <= dpq_pkg::FILL_W'(count_r);
      out_r.is_empty      <= is_empty;
      out_r.is_full       <= is_full;
      out_r.error_code    <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `DPQ_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after accept")
  `DPQ_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  `DPQ_ASSERT_NOW(a_empty_flag, out_valid,
    out_item.is_empty == (out_item.fill_level == '0), "empty flag disagrees with fill")
  `DPQ_ASSERT_NOW(a_empty_zero, out_valid && out_item.is_empty,
    out_item.min_value == '0 && out_item.max_value == '0, "empty queue reports values")
  `DPQ_ASSERT_NOW(a_err_removed, out_valid && out_item.error_code != dpq_pkg::ERR_NONE,
    out_item.removed_value == '0, "failed request reports a removed value")

endmodule
`default_nettype wire

>>> rtl/core/dpq_cell.sv
// One cell of the sorted chain: holds one value and its valid bit.
`default_nettype none
module dpq_cell (
  input  wire                                clk,
  input  wire                                rst_n,
  input  dpq_pkg::cell_op_t                  op,
  input  wire logic signed [dpq_pkg::VALUE_W-1:0] ins_val,
  input  dpq_pkg::cell_link_t                lnk_left,
  input  dpq_pkg::cell_link_t                lnk_right,
  output dpq_pkg::cell_link_t                lnk,
  output logic [dpq_pkg::VALUE_W-1:0]        last_val
);

  logic                              vld_r, vld_nxt;
  logic signed [dpq_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic                              keep;

  // keep is true on a prefix of the chain: values not above the new one stay
  assign keep     = vld_r && (val_r <= ins_val);
  assign lnk.vld  = vld_r;
  assign lnk.keep = keep;
  assign lnk.val  = val_r;
  assign last_val = (vld_r && !lnk_right.vld) ? val_r : '0;

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    case (op)
      dpq_pkg::OP_INSERT: begin
        if (!keep) begin
          if (lnk_left.keep) begin
            vld_nxt = 1'b1;
            val_nxt = ins_val;
          end else begin
            vld_nxt = lnk_left.vld;
            val_nxt = lnk_left.val;
          end
        end
      end
      dpq_pkg::OP_POP_MIN: begin
        vld_nxt = lnk_right.vld;
        val_nxt = lnk_right.val;
      end
      dpq_pkg::OP_POP_MAX: begin
        if (vld_r && !lnk_right.vld) begin
          vld_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

>>> tb/dpq_checker.sv
// Checker for the double-ended priority queue: keeps a sorted copy and checks every response.
module dpq_checker
  import dpq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  in_item_t   in_item,
  input  wire        out_valid,
  input  out_item_t  out_item,
  output int         mismatch_count,
  output int         outstanding,
  output int         results_checked,
  output int         full_refusals,
  output int         empty_refusals
);

  localparam int QUEUE_DEPTH = CAPACITY_DEF;

  // Held values, ascending signed order.
  logic signed [VALUE_W-1:0] held_sorted[$];
  out_item_t                 pending_responses[$];
  out_item_t                 want;
  int                        mismatches;

  initial begin
    mismatches      = 0;
    mismatch_count  = 0;
    outstanding     = 0;
    results_checked = 0;
    full_refusals   = 0;
    empty_refusals  = 0;
  end

  // Apply one request to the copy and return the response it should produce.
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t                 resp;
    int                        pos;
    logic signed [VALUE_W-1:0] v;
    resp = '0;
    v    = req.value;
    case (req.req_type)
      REQ_INSERT: begin
        if (held_sorted.size() >= QUEUE_DEPTH) begin
          resp.error_code = ERR_FULL;
        end else begin
          pos = held_sorted.size();
          while (pos > 0 && held_sorted[pos-1] > v) pos--;
          held_sorted.insert(pos, v);
        end
      end
      REQ_POP_MIN: begin
        if (held_sorted.size() == 0) resp.error_code = ERR_EMPTY;
        else resp.removed_value = held_sorted.pop_front();
      end
      REQ_POP_MAX: begin
        if (held_sorted.size() == 0) resp.error_code = ERR_EMPTY;
        else resp.removed_value = held_sorted.pop_back();
      end
      default: ;
    endcase
    if (held_sorted.size() > 0) begin
      resp.min_value = held_sorted[0];
      resp.max_value = held_sorted[held_sorted.size()-1];
    end
    resp.fill_level = FILL_W'(held_sorted.size());
    resp.is_empty   = (held_sorted.size() == 0);
    resp.is_full    = (held_sorted.size() >= QUEUE_DEPTH);
    return resp;
  endfunction

  task automatic compare_field(string name, logic [VALUE_W-1:0] expd, logic [VALUE_W-1:0] got);
    if (expd !== got) begin
      $error("%s: expected %0h, got %0h", name, expd, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_sorted.delete();
      pending_responses.delete();
    end else begin
      if (out_valid) begin
        if (pending_responses.size() == 0) begin
          $error("response with nothing outstanding: %0h", out_item);
          mismatches++;
        end else begin
          want = pending_responses.pop_front();
          compare_field("removed_value", want.removed_value, out_item.removed_value);
          compare_field("min_value", want.min_value, out_item.min_value);
          compare_field("max_value", want.max_value, out_item.max_value);
          compare_field("fill_level", want.fill_level, out_item.fill_level);
          compare_field("is_empty", want.is_empty, out_item.is_empty);
          compare_field("is_full", want.is_full, out_item.is_full);
          compare_field("error_code", want.error_code, out_item.error_code);
          results_checked <= results_checked + 1;
        end
      end
      if (start && !busy) begin
        want = serve_request(in_item);
        if (want.error_code == ERR_FULL) full_refusals <= full_refusals + 1;
        if (want.error_code == ERR_EMPTY) empty_refusals <= empty_refusals + 1;
        pending_responses.push_back(want);
      end
    end
    mismatch_count <= mismatches;
    outstanding    <= pending_responses.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the priority queue testbench: clock, reset, request stimulus and verdict.
module tb_top;
  import dpq_pkg::*;

  // Request code 3 has no meaning to the block: it must act as a no-op.
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int full_refusals;
  int empty_refusals;
  int inserts_sent;
  int removals_sent;
  int nops_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  dpq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  function automatic in_item_t make_item(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] v);
    in_item_t it;
    it.req_type = req;
    it.value    = v;
    return it;
  endfunction

  // Present one item and hold it until the edge that takes it. busy is read
  // straight after the edge, so it is the value the block saw at that edge.
  // start is left high: the caller either follows with the next item or
  // drops start itself, so start gets one assignment per time step.
  task automatic send_item(in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    case (it.req_type)
      REQ_INSERT: inserts_sent++;
      REQ_NOP:    nops_sent++;
      default:    removals_sent++;
    endcase
    do @(posedge clk); while (busy);
  endtask

  // Idle the sender for a random stretch; the chance of idling each cycle is
  // idle_pct in a hundred, so gaps of every length land on every busy phase.
  task automatic sender_gap(int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold the sender off until every outstanding response has been checked.
  task automatic drain_responses();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mix wide random values with extremes and a narrow band, the narrow band
  // making duplicates and near ties common.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(15)) - 8;
      6: begin
        case ($urandom_range(5))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return VAL_MAX - 1;
          3:       return VAL_MIN + 1;
          4:       return -1;
          default: return 0;
        endcase
      end
      default:    return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  // Random traffic: insert_pct steers the fill level towards full or empty so
  // that both refusal cases are reached and dwelt on.
  task automatic random_phase(int count, int idle_pct, int insert_pct);
    logic [REQ_W-1:0] req;
    repeat (count) begin
      if ($urandom_range(99) < 3) req = REQ_NOP;
      else if ($urandom_range(99) < insert_pct) req = REQ_INSERT;
      else if ($urandom_range(1) == 0) req = REQ_POP_MIN;
      else req = REQ_POP_MAX;
      sender_gap(idle_pct);
      send_item(make_item(req, pick_value()));
    end
  endtask

  initial begin
    inserts_sent  = 0;
    removals_sent = 0;
    nops_sent     = 0;

    // Hold reset at the start, then release it once for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Removals and a no-op on the empty queue.
    send_item(make_item(REQ_POP_MIN, 0));
    send_item(make_item(REQ_POP_MAX, -1));
    send_item(make_item(REQ_NOP, 0));
    // Extremes, zero, both signs and duplicates.
    send_item(make_item(REQ_INSERT, VAL_MAX));
    send_item(make_item(REQ_INSERT, VAL_MIN));
    send_item(make_item(REQ_INSERT, 0));
    send_item(make_item(REQ_INSERT, -1));
    send_item(make_item(REQ_INSERT, 1));
    send_item(make_item(REQ_INSERT, 0));
    send_item(make_item(REQ_INSERT, VAL_MAX));
    send_item(make_item(REQ_NOP, VAL_MIN));
    // Take the duplicate maxima, then the minimum; removal values are ignored.
    send_item(make_item(REQ_POP_MAX, VAL_MIN));
    send_item(make_item(REQ_POP_MAX, 0));
    send_item(make_item(REQ_POP_MIN, VAL_MAX));
    send_item(make_item(REQ_INSERT, 32'sh5555_5555));
    send_item(make_item(REQ_INSERT, 32'shaaaa_aaaa));
    // Drain from both ends down to empty and one past it.
    send_item(make_item(REQ_POP_MIN, 0));
    send_item(make_item(REQ_POP_MAX, 0));
    send_item(make_item(REQ_POP_MIN, 0));
    send_item(make_item(REQ_POP_MIN, 0));
    send_item(make_item(REQ_POP_MAX, 0));
    send_item(make_item(REQ_POP_MIN, 0));
    send_item(make_item(REQ_POP_MAX, 0));
    send_item(make_item(REQ_NOP, -1));
    drain_responses();

    // Random phases: back to back, heavy idling, light idling; alternate
    // filling to capacity with draining to empty, ending with a mixed phase.
    random_phase(325, 0, 75);
    drain_responses();
    random_phase(325, 65, 20);
    drain_responses();
    random_phase(325, 17, 75);
    drain_responses();
    random_phase(325, 0, 25);
    drain_responses();
    random_phase(325, 65, 55);

    // Drop start, wait for the last responses, then leave room for strays.
    drain_responses();
    repeat (10) @(posedge clk);

    $display("Covered %0d inserts, %0d removals and %0d no-op codes; %0d responses checked",
             inserts_sent, removals_sent, nops_sent, results_checked);
    $display("Inserts refused at capacity: %0d, removals refused on empty: %0d",
             full_refusals, empty_refusals);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
